### hdl/msd_pkg.sv
// ----------------------------------------------------------------------------
// msd_pkg
// Shared widths, codes and controller/datapath command types for the sample
// mean and standard deviation unit.
// ----------------------------------------------------------------------------
package msd_pkg;

    // Field widths
    localparam int SAMPLE_W        = 18;
    localparam int OUT_CNT_W       = 5;
    localparam int MAX_SAMPLES_DEF = 16;

    // Sample code that marks "no reading" (-1.0 C with 9 fraction bits)
    localparam logic [SAMPLE_W-1:0] SENTINEL = 18'h3FE00;

    // Datapath operation codes
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NONE = 3'd0;
    localparam logic [OP_W-1:0] OP_MULN = 3'd1; // acc  = n * sumsq
    localparam logic [OP_W-1:0] OP_MULS = 3'd2; // acc -= |sum| * |sum|
    localparam logic [OP_W-1:0] OP_DIVM = 3'd3; // q    = |sum| / n
    localparam logic [OP_W-1:0] OP_DIVV = 3'd4; // q    = acc / (n * n)
    localparam logic [OP_W-1:0] OP_SQRT = 3'd5; // root = isqrt(q)

    // Commands from controller to datapath
    typedef struct packed {
        logic            acc;      // accumulate the accepted sample
        logic [OP_W-1:0] op;       // operation of the current phase
        logic            init;     // set up operands for op
        logic            load_out; // load result register, clear accumulators
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic cnt_zero;  // no valid sample held
        logic step_done; // current iteration is the last of the phase
    } t_dp_status;

endpackage

### hdl/msd_datapath.sv
// ----------------------------------------------------------------------------
// msd_datapath
// Accumulators, shared shift-add multiplier, restoring divider, digit-by-digit
// square root and the result register.
// ----------------------------------------------------------------------------
module msd_datapath #(
    parameter int MAX_SAMPLES = msd_pkg::MAX_SAMPLES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  msd_pkg::t_dp_cmd                    i_cmd,
    input  logic signed [msd_pkg::SAMPLE_W-1:0] i_sample,
    output msd_pkg::t_dp_status                 o_status,
    output logic signed [msd_pkg::SAMPLE_W-1:0] o_mean,
    output logic        [msd_pkg::SAMPLE_W-1:0] o_std_dev,
    output logic        [msd_pkg::OUT_CNT_W-1:0] o_valid_count,
    output logic                                o_no_valid
);

    localparam int XW = msd_pkg::SAMPLE_W;
    localparam int CW = $clog2(MAX_SAMPLES + 1); // sample count
    localparam int SW = XW + CW;                 // signed running sum
    localparam int QW = 2 * XW + CW;             // running sum of squares
    localparam int NW = 2 * (XW + CW);           // n*sumsq and the quotients
    localparam int HW = NW / 2;                  // square root
    localparam int DW = 2 * CW;                  // divisor n*n
    localparam int KW = $clog2(NW);              // iteration counter
    localparam int OUT_CNT_W_L = msd_pkg::OUT_CNT_W;

    // Accumulators
    logic signed [SW-1:0] r_sum;
    logic        [QW-1:0] r_sumsq;
    logic        [CW-1:0] r_cnt;

    // Iteration registers
    logic [NW-1:0]   r_acc;
    logic [NW-1:0]   r_ma;
    logic [SW-1:0]   r_mb;
    logic [NW-1:0]   r_dvd;
    logic [DW-1:0]   r_rem;
    logic [DW-1:0]   r_dvs;
    logic [HW+1:0]   r_srem;
    logic [HW-1:0]   r_root;
    logic [KW-1:0]   r_step;
    logic [XW-1:0]   r_mean;

    // Result register
    logic [XW-1:0]        r_o_mean;
    logic [XW-1:0]        r_o_sd;
    logic [OUT_CNT_W_L-1:0] r_o_cnt;
    logic                 r_o_nv;

    logic                  w_take;
    logic [XW-1:0]         w_smag;
    logic [2*XW-1:0]       w_sq;
    logic [SW-1:0]         w_sum_mag;
    logic                  w_step;
    logic [DW:0]           w_rem_sh;
    logic [DW+1:0]         w_diff;
    logic [HW+1:0]         w_srem_sh;
    logic [HW+1:0]         w_trial;
    logic [XW-1:0]         w_q;
    logic [CW+OUT_CNT_W_L-1:0] w_cnt_ext;

    // Sample qualification and square
    assign w_take    = i_cmd.acc && (i_sample != msd_pkg::SENTINEL)
                       && (r_cnt < CW'(MAX_SAMPLES));
    assign w_smag    = i_sample[XW-1] ? XW'(-i_sample) : XW'(i_sample);
    assign w_sq      = w_smag * w_smag;
    assign w_sum_mag = r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);

    // One iteration of the active phase
    assign w_step    = (i_cmd.op != msd_pkg::OP_NONE) && !i_cmd.init;

    // Divider and root trial values
    assign w_rem_sh  = {r_rem, r_dvd[NW-1]};
    assign w_diff    = {1'b0, w_rem_sh} - {2'b00, r_dvs};
    assign w_srem_sh = {r_srem[HW-1:0], r_dvd[NW-1:NW-2]};
    assign w_trial   = {r_root, 2'b01};
    assign w_q       = r_dvd[XW-1:0];
    assign w_cnt_ext = {{OUT_CNT_W_L{1'b0}}, r_cnt};

    // Accumulate samples, clear on result load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load_out) begin
            r_sum   <= '0;
            r_sumsq <= '0;
            r_cnt   <= '0;
        end else if (w_take) begin
            r_sum   <= r_sum + SW'(i_sample);
            r_sumsq <= r_sumsq + QW'(w_sq);
            r_cnt   <= r_cnt + CW'(1);
        end
    end

    // Iteration counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_cmd.init) begin
            unique case (i_cmd.op)
                msd_pkg::OP_MULN: r_step <= KW'(CW - 1);
                msd_pkg::OP_MULS: r_step <= KW'(SW - 1);
                msd_pkg::OP_DIVM: r_step <= KW'(NW - 1);
                msd_pkg::OP_DIVV: r_step <= KW'(NW - 1);
                msd_pkg::OP_SQRT: r_step <= KW'(HW - 1);
                default:          r_step <= '0;
            endcase
        end else if (w_step && r_step != '0) begin
            r_step <= r_step - KW'(1);
        end
    end

    // Set up and advance the shared arithmetic
    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            unique case (i_cmd.op)
                msd_pkg::OP_MULN: begin
                    r_acc <= '0;
                    r_ma  <= NW'(r_sumsq);
                    r_mb  <= SW'(r_cnt);
                end
                msd_pkg::OP_MULS: begin
                    r_ma  <= NW'(w_sum_mag);
                    r_mb  <= w_sum_mag;
                end
                msd_pkg::OP_DIVM: begin
                    r_dvd <= NW'(w_sum_mag);
                    r_rem <= '0;
                    r_dvs <= DW'(r_cnt);
                end
                msd_pkg::OP_DIVV: begin
                    r_mean <= r_sum[SW-1] ? XW'(-w_q) : w_q;
                    r_dvd  <= r_acc;
                    r_rem  <= '0;
                    r_dvs  <= DW'(r_cnt) * DW'(r_cnt);
                end
                msd_pkg::OP_SQRT: begin
                    r_srem <= '0;
                    r_root <= '0;
                end
                default: ;
            endcase
        end else if (w_step) begin
            unique case (i_cmd.op)
                msd_pkg::OP_MULN: begin
                    if (r_mb[0]) r_acc <= r_acc + r_ma;
                    r_ma <= {r_ma[NW-2:0], 1'b0};
                    r_mb <= {1'b0, r_mb[SW-1:1]};
                end
                msd_pkg::OP_MULS: begin
                    if (r_mb[0]) r_acc <= r_acc - r_ma;
                    r_ma <= {r_ma[NW-2:0], 1'b0};
                    r_mb <= {1'b0, r_mb[SW-1:1]};
                end
                msd_pkg::OP_DIVM, msd_pkg::OP_DIVV: begin
                    if (!w_diff[DW+1]) begin
                        r_rem <= w_diff[DW-1:0];
                        r_dvd <= {r_dvd[NW-2:0], 1'b1};
                    end else begin
                        r_rem <= w_rem_sh[DW-1:0];
                        r_dvd <= {r_dvd[NW-2:0], 1'b0};
                    end
                end
                msd_pkg::OP_SQRT: begin
                    if (w_srem_sh >= w_trial) begin
                        r_srem <= w_srem_sh - w_trial;
                        r_root <= {r_root[HW-2:0], 1'b1};
                    end else begin
                        r_srem <= w_srem_sh;
                        r_root <= {r_root[HW-2:0], 1'b0};
                    end
                    r_dvd <= {r_dvd[NW-3:0], 2'b00};
                end
                default: ;
            endcase
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_mean <= (r_cnt == '0) ? '0 : r_mean;
            r_o_sd   <= (r_cnt == '0) ? '0 : r_root[XW-1:0];
            r_o_cnt  <= w_cnt_ext[OUT_CNT_W_L-1:0];
            r_o_nv   <= (r_cnt == '0);
        end
    end

    assign o_status.cnt_zero  = (r_cnt == '0);
    assign o_status.step_done = (r_step == '0);

    assign o_mean        = r_o_mean;
    assign o_std_dev     = r_o_sd;
    assign o_valid_count = r_o_cnt;
    assign o_no_valid    = r_o_nv;

endmodule

### hdl/msd_ctrl.sv
// ----------------------------------------------------------------------------
// msd_ctrl
// Controller: accepts samples, sequences the closing arithmetic phases and
// owns the output valid flag.
// ----------------------------------------------------------------------------
module msd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_last,
    input  logic                i_stall,
    input  msd_pkg::t_dp_status i_status,
    output msd_pkg::t_dp_cmd    o_cmd,
    output logic                o_stall,
    output logic                o_valid
);

    localparam logic [2:0] S_ACC  = 3'd0;
    localparam logic [2:0] S_MULN = 3'd1;
    localparam logic [2:0] S_MULS = 3'd2;
    localparam logic [2:0] S_DIVM = 3'd3;
    localparam logic [2:0] S_DIVV = 3'd4;
    localparam logic [2:0] S_SQRT = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_first;
    logic       n_first;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_accept;

    assign w_accept = i_valid && (r_state == S_ACC);

    // Next state and datapath commands
    always_comb begin
        n_state        = r_state;
        n_first        = 1'b0;
        o_cmd.acc      = w_accept;
        o_cmd.op       = msd_pkg::OP_NONE;
        o_cmd.init     = r_first;
        o_cmd.load_out = 1'b0;
        unique case (r_state)
            S_ACC: begin
                o_cmd.init = 1'b0;
                if (w_accept && i_last) begin
                    n_state = S_MULN;
                    n_first = 1'b1;
                end
            end
            S_MULN: begin
                o_cmd.op = msd_pkg::OP_MULN;
                if (r_first && i_status.cnt_zero) begin
                    n_state = S_OUT;
                end else if (!r_first && i_status.step_done) begin
                    n_state = S_MULS;
                    n_first = 1'b1;
                end
            end
            S_MULS: begin
                o_cmd.op = msd_pkg::OP_MULS;
                if (!r_first && i_status.step_done) begin
                    n_state = S_DIVM;
                    n_first = 1'b1;
                end
            end
            S_DIVM: begin
                o_cmd.op = msd_pkg::OP_DIVM;
                if (!r_first && i_status.step_done) begin
                    n_state = S_DIVV;
                    n_first = 1'b1;
                end
            end
            S_DIVV: begin
                o_cmd.op = msd_pkg::OP_DIVV;
                if (!r_first && i_status.step_done) begin
                    n_state = S_SQRT;
                    n_first = 1'b1;
                end
            end
            S_SQRT: begin
                o_cmd.op = msd_pkg::OP_SQRT;
                if (!r_first && i_status.step_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_cmd.init = 1'b0;
                // load once the result register is free or being emptied
                if (!r_out_valid || !i_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_ACC;
                end
            end
            default: begin
                o_cmd.init = 1'b0;
                n_state    = S_ACC;
            end
        endcase
    end

    // Output valid: set on load, drop when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACC;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_first     <= n_first;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_ACC);
    assign o_valid = r_out_valid;

endmodule

### hdl/sample_mean_and_std_dev_unit.sv
// ----------------------------------------------------------------------------
// sample_mean_and_std_dev_unit
// Mean and population standard deviation of a marked run of samples.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall): one 18-bit signed sample with 9 fraction
// bits per transaction, i_last closing the run. Code -512 (-1.0 C) is skipped;
// valid samples beyond MAX_SAMPLES in one run are ignored.
// Samples are taken one per cycle while o_stall is low. The transaction
// carrying i_last starts the closing arithmetic and o_stall stays high until
// the result is registered. The closing arithmetic runs on the bit-serial
// multiplier, the restoring divider (run twice) and the two-bit-per-step
// square root, all sharing one datapath.
// Output channel (o_valid / i_stall): one result transaction per run. The
// result register lets a new run accumulate while the result waits; a second
// closing run holds in the final step until the earlier result is taken.
// Reset (synchronous, active low) clears the accumulators and drops o_valid.
// ----------------------------------------------------------------------------
module sample_mean_and_std_dev_unit #(
    parameter int MAX_SAMPLES = msd_pkg::MAX_SAMPLES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [msd_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic                                 i_last,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [msd_pkg::SAMPLE_W-1:0]  o_mean,
    output logic        [msd_pkg::SAMPLE_W-1:0]  o_std_dev,
    output logic        [msd_pkg::OUT_CNT_W-1:0] o_valid_count,
    output logic                                 o_no_valid
);

    msd_pkg::t_dp_cmd    w_cmd;
    msd_pkg::t_dp_status w_status;

    // Sequencer
    msd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_last   (i_last),
        .i_stall  (i_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_stall  (o_stall),
        .o_valid  (o_valid)
    );

    // Arithmetic
    msd_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_sample      (i_sample),
        .o_status      (w_status),
        .o_mean        (o_mean),
        .o_std_dev     (o_std_dev),
        .o_valid_count (o_valid_count),
        .o_no_valid    (o_no_valid)
    );

endmodule

### hdl/msd_checker.sv
// ----------------------------------------------------------------------------
// msd_checker
// Port-level checks for the sample mean and standard deviation unit.
// ----------------------------------------------------------------------------
module msd_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_valid,
    input logic                                 o_stall,
    input logic                                 i_last,
    input logic                                 o_valid,
    input logic                                 i_stall,
    input logic signed [msd_pkg::SAMPLE_W-1:0]  o_mean,
    input logic        [msd_pkg::SAMPLE_W-1:0]  o_std_dev,
    input logic        [msd_pkg::OUT_CNT_W-1:0] o_valid_count,
    input logic                                 o_no_valid
);

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_mean) && $stable(o_std_dev)
            && $stable(o_valid_count) && $stable(o_no_valid))
        else $error("result changed while stalled");

    // An empty run reports zeros
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_no_valid |-> o_mean == '0 && o_std_dev == '0
            && o_valid_count == '0)
        else $error("empty run with non-zero fields");

    // Deviation of 18-bit samples never exceeds half the code range
    a_sd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_std_dev <= 18'd131072)
        else $error("std_dev out of range");

    // Closing a run stops input while the result is computed
    a_close_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_last |=> o_stall)
        else $error("input not held after closing transaction");

endmodule

bind sample_mean_and_std_dev_unit msd_checker u_msd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .i_last        (i_last),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_mean        (o_mean),
    .o_std_dev     (o_std_dev),
    .o_valid_count (o_valid_count),
    .o_no_valid    (o_no_valid)
);

### tb/sv/sample_mean_and_std_dev_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_mean_and_std_dev_unit_tb
// Drives marked runs of fixed-point temperature samples into the unit and
// checks mean, standard deviation, count and empty-run flag of every closed
// run against a cycle-free prediction. The runs cover directed corner runs
// and randomised runs under several idling patterns, plus a long output
// hold-off that backs the unit up into its input.
// ----------------------------------------------------------------------------

typedef struct {
    logic signed [msd_pkg::SAMPLE_W-1:0]  mean;
    logic        [msd_pkg::SAMPLE_W-1:0]  std_dev;
    logic        [msd_pkg::OUT_CNT_W-1:0] valid_count;
    logic                                 no_valid;
} t_run_stats;

// Accumulates accepted samples and queues the statistics of each closed run
class run_stats_scoreboard;
    longint     acc_sum;
    longint     acc_sum_sq;
    int         acc_count;
    t_run_stats expected_stats[$];
    int         mismatches;

    function void take_sample(logic signed [msd_pkg::SAMPLE_W-1:0] smp, logic last_flag);
        t_run_stats stats;
        longint     n;
        longint     mean_full;
        bit [63:0]  rem;
        bit [63:0]  root;
        bit [63:0]  probe;
        // skip the no-reading code and anything past the per-run capacity
        if (smp != msd_pkg::SENTINEL && acc_count < msd_pkg::MAX_SAMPLES_DEF) begin
            acc_sum    += smp;
            acc_sum_sq += longint'(smp) * longint'(smp);
            acc_count++;
        end
        if (!last_flag) return;

        if (acc_count == 0) begin
            stats.mean        = '0;
            stats.std_dev     = '0;
            stats.valid_count = '0;
            stats.no_valid    = 1'b1;
        end else begin
            n         = acc_count;
            mean_full = acc_sum / n;
            rem       = (n * acc_sum_sq - acc_sum * acc_sum) / (n * n);
            // floor square root, two bits per step
            root  = 0;
            probe = 64'd1 << 62;
            while (probe > rem) probe >>= 2;
            while (probe != 0) begin
                if (rem >= root + probe) begin
                    rem  = rem - (root + probe);
                    root = (root >> 1) + probe;
                end else begin
                    root = root >> 1;
                end
                probe >>= 2;
            end
            stats.mean        = mean_full[msd_pkg::SAMPLE_W-1:0];
            stats.std_dev     = root[msd_pkg::SAMPLE_W-1:0];
            stats.valid_count = n[msd_pkg::OUT_CNT_W-1:0];
            stats.no_valid    = 1'b0;
        end
        expected_stats.push_back(stats);
        acc_sum    = 0;
        acc_sum_sq = 0;
        acc_count  = 0;
    endfunction

    function void check_stats(logic signed [msd_pkg::SAMPLE_W-1:0]  mean,
                              logic        [msd_pkg::SAMPLE_W-1:0]  std_dev,
                              logic        [msd_pkg::OUT_CNT_W-1:0] valid_count,
                              logic                                 no_valid);
        t_run_stats exp_stats;
        if (expected_stats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: mean %0d std_dev %0d count %0d no_valid %0b",
                         mean, std_dev, valid_count, no_valid);
            return;
        end
        exp_stats = expected_stats.pop_front();
        if (mean !== exp_stats.mean || std_dev !== exp_stats.std_dev ||
            valid_count !== exp_stats.valid_count || no_valid !== exp_stats.no_valid) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result mismatch at %0t: expected %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b",
                         $realtime, exp_stats.mean, exp_stats.std_dev,
                         exp_stats.valid_count, exp_stats.no_valid,
                         mean, std_dev, valid_count, no_valid);
        end
    endfunction

    function int pending();
        return expected_stats.size();
    endfunction
endclass

module sample_mean_and_std_dev_unit_tb;

    localparam int                         SAMPLE_W    = msd_pkg::SAMPLE_W;
    localparam int                         OUT_CNT_W   = msd_pkg::OUT_CNT_W;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX  = 18'sh1FFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN  = 18'sh20000;
    localparam int                         CLOSE_WAIT  = 200;
    localparam int                         CYCLE_LIMIT = 2000000;

    // Run shapes for the random part
    typedef enum int {STYLE_FULL, STYLE_CLUSTER, STYLE_EXTREME} t_sample_style;

    logic                        i_clk         = 1'b0;
    logic                        i_rst_n       = 1'b0;
    logic                        i_valid       = 1'b0;
    logic signed [SAMPLE_W-1:0]  i_sample      = '0;
    logic                        i_last        = 1'b0;
    logic                        i_stall       = 1'b0;
    logic                        o_stall;
    logic                        o_valid;
    logic signed [SAMPLE_W-1:0]  o_mean;
    logic        [SAMPLE_W-1:0]  o_std_dev;
    logic        [OUT_CNT_W-1:0] o_valid_count;
    logic                        o_no_valid;

    run_stats_scoreboard stats;
    int                  send_idle_pct = 0;
    int                  stall_pct     = 0;
    int                  hold_cycles   = 0;
    int                  samples_sent  = 0;
    int                  cycle_count   = 0;

    sample_mean_and_std_dev_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_sample      (i_sample),
        .i_last        (i_last),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_mean        (o_mean),
        .o_std_dev     (o_std_dev),
        .o_valid_count (o_valid_count),
        .o_no_valid    (o_no_valid)
    );

    // Clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side: check each accepted transaction, stall at random or hold off
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall)
            stats.check_stats(o_mean, o_std_dev, o_valid_count, o_no_valid);
        if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Offer one sample, idling first at random, and return once it is taken
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp, input logic last_flag);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= smp;
        i_last   <= last_flag;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        stats.take_sample(smp, last_flag);
        samples_sent++;
    endtask

    // Drop valid and wait until every closed run has delivered its result
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (stats.pending() != 0);
    endtask

    // One random run: mostly well formed, some saturating, empty or broken
    task automatic send_random_run();
        int                         kind;
        int                         len;
        int                         base;
        int                         spread;
        int                         v;
        int                         k;
        bit [31:0]                  rnd;
        t_sample_style              style;
        logic signed [SAMPLE_W-1:0] smp;
        logic                       last_flag;
        kind   = $urandom_range(99);
        k      = $urandom_range(99);
        style  = (k < 40) ? STYLE_FULL : (k < 85) ? STYLE_CLUSTER : STYLE_EXTREME;
        base   = int'($urandom_range(262143)) - 131072;
        spread = 1 << $urandom_range(10);
        if (kind < 70)      len = $urandom_range(12, 1);
        else if (kind < 80) len = $urandom_range(20, 16);
        else if (kind < 85) len = $urandom_range(3, 1);
        else                len = $urandom_range(8, 1);

        for (int i = 0; i < len; i++) begin
            last_flag = (i == len - 1);
            if (kind >= 80 && kind < 85) begin
                // run with no valid sample at all
                smp = msd_pkg::SENTINEL;
            end else if (kind >= 85) begin
                // noise: raw codes, run marker anywhere or nowhere
                rnd       = $urandom;
                smp       = rnd[SAMPLE_W-1:0];
                last_flag = ($urandom_range(99) < 25);
            end else if ($urandom_range(99) < 8) begin
                smp = msd_pkg::SENTINEL;
            end else begin
                case (style)
                    STYLE_FULL: begin
                        rnd = $urandom;
                        smp = rnd[SAMPLE_W-1:0];
                    end
                    STYLE_CLUSTER: begin
                        v = base + int'($urandom_range(2 * spread)) - spread;
                        if (v > 131071)  v = 131071;
                        if (v < -131072) v = -131072;
                        smp = v[SAMPLE_W-1:0];
                    end
                    default: begin
                        case ($urandom_range(4))
                            0:       smp = SAMPLE_MAX;
                            1:       smp = SAMPLE_MIN;
                            2:       smp = '0;
                            3:       smp = -18'sd1;
                            default: smp = 18'sd1;
                        endcase
                    end
                endcase
            end
            send_sample(smp, last_flag);
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_chance, input int quota);
        int start;
        send_idle_pct = idle_pct;
        stall_pct     = stall_chance;
        start         = samples_sent;
        while (samples_sent - start < quota) send_random_run();
    endtask

    // Stimulus
    initial begin
        stats = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single extreme samples
        send_sample(SAMPLE_MAX, 1'b1);
        send_sample(SAMPLE_MIN, 1'b1);
        // widest spread
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b1);
        // empty run closed by the no-reading code
        send_sample(msd_pkg::SENTINEL, 1'b1);
        // full run: the no-reading code and a seventeenth sample are skipped
        for (int i = 0; i < msd_pkg::MAX_SAMPLES_DEF; i++) send_sample(SAMPLE_MAX, 1'b0);
        send_sample(msd_pkg::SENTINEL, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        // negative mean truncated toward zero, no-reading code on the last item
        send_sample(-18'sd3, 1'b0);
        send_sample('0, 1'b0);
        send_sample(msd_pkg::SENTINEL, 1'b1);

        run_phase(0, 0, 340);
        run_phase(79, 0, 340);
        run_phase(0, 79, 340);
        run_phase(23, 23, 340);

        // long output hold-off while the input keeps offering runs
        drain_results();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_cycles   = 800;
        run_phase(0, 0, 90);
        drain_results();

        repeat (CLOSE_WAIT) @(posedge i_clk);
        if (stats.mismatches == 0 && stats.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### files.f
hdl/msd_pkg.sv
hdl/msd_datapath.sv
hdl/msd_ctrl.sv
hdl/sample_mean_and_std_dev_unit.sv
hdl/msd_checker.sv
tb/sv/sample_mean_and_std_dev_unit_tb.sv
